// File: hdl/assert_macros.svh
// Assertion macros used by the periodic timer table RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/ptt_pkg.sv
// Package for the periodic timer table: sizes, codes and shared types.
// No dependencies; every RTL module of the block refers to it by scoped names.
`timescale 1ns / 1ps

package ptt_pkg;

	localparam int TIMER_SLOTS = 16;
	localparam int MAX_RESULTS = 16;
	localparam int IDX_W = $clog2(TIMER_SLOTS);
	localparam int CNT_W = $clog2(TIMER_SLOTS + 1);
	localparam int RES_W = $clog2(MAX_RESULTS + 1);

	typedef enum logic [1:0] {
		KIND_CREATE = 2'd0,
		KIND_DROP   = 2'd1,
		KIND_TICK   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_FIRED     = 3'd0,
		ST_NO_FIRE   = 3'd1,
		ST_CREATED   = 3'd2,
		ST_FULL      = 3'd3,
		ST_DROPPED   = 3'd4,
		ST_NOT_FOUND = 3'd5
	} status_t;

	typedef struct packed {
		logic [7:0]  id;
		logic [31:0] period;
		logic [31:0] last_time;
	} entry_t;

	typedef struct packed {
		logic [7:0] id;
		status_t    status;
		logic       last;
	} res_t;

	typedef struct packed {
		logic             busy;
		logic [CNT_W-1:0] count;
	} stat_t;

endpackage

// File: hdl/periodic_timer_table_unit.sv
// Each create, drop or tick ends with its final result in the output register: a create
// appends the entry or reports a full table; a drop searches the table and, on a match,
// shifts the entries behind it down; a tick walks every entry. Fired results stream out during the walk.
// The input stalls until the final result is loaded; a held output can delay a tick walk
// and the final result. Reset empties the table; entry contents stay undefined.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module periodic_timer_table_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [7:0]  timer_id,
	input  logic [31:0] period,
	input  logic [31:0] now_time,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  fired_id,
	output logic [2:0]  status,
	output logic        last_result
);

	logic           push;
	logic           free;
	logic           known_kind;
	ptt_pkg::res_t  res;
	ptt_pkg::stat_t stat;

	assign in_stall = stat.busy;
	assign known_kind = kind inside {ptt_pkg::KIND_CREATE, ptt_pkg::KIND_DROP,
		ptt_pkg::KIND_TICK};

	ptt_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.timer_id (timer_id),
		.period   (period),
		.now_time (now_time),
		.out_free (free),
		.push     (push),
		.res      (res),
		.stat     (stat)
	);

	ptt_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.res         (res),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.fired_id    (fired_id),
		.status      (status),
		.last_result (last_result),
		.free        (free)
	);

	`ASSERT_IMPL(a_count_range, 1'b1, stat.count <= ptt_pkg::TIMER_SLOTS, "entry count overflow")
	`ASSERT_NEXT(a_busy_after_item, in_valid && !in_stall && known_kind, in_stall, "item not taken up")
	`ASSERT_IMPL(a_push_has_room, push, !out_valid || !out_stall, "result pushed into a held output")

endmodule

// File: hdl/ptt_due.sv
// Due check of one timer entry: 33-bit sum of last time and period against now.
// Depends on ptt_pkg for the entry layout.
`timescale 1ns / 1ps

module ptt_due (
	input  ptt_pkg::entry_t entry,
	input  logic [31:0]     now_time,
	output logic            fire
);

	logic [32:0] due;

	assign due = {1'b0, entry.last_time} + {1'b0, entry.period};
	assign fire = due < {1'b0, now_time};

endmodule

// File: hdl/ptt_out.sv
// Output register stage of the periodic timer table.
// Depends on ptt_pkg for the result type.
`timescale 1ns / 1ps

module ptt_out (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ptt_pkg::res_t res,
	input  logic          out_stall,
	output logic          out_valid,
	output logic [7:0]    fired_id,
	output logic [2:0]    status,
	output logic          last_result,
	output logic          free
);

	logic          valid_q;
	ptt_pkg::res_t data_q;

	assign free = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign fired_id = data_q.id;
	assign status = data_q.status;
	assign last_result = data_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= res;
		end
	end

endmodule

// File: hdl/ptt_seq.sv
// Sequencer and timer table memory of the periodic timer table.
// Depends on ptt_pkg and on ptt_due, the due check.
`timescale 1ns / 1ps

module ptt_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [1:0]       kind,
	input  logic [7:0]       timer_id,
	input  logic [31:0]      period,
	input  logic [31:0]      now_time,
	input  logic             out_free,
	output logic             push,
	output ptt_pkg::res_t    res,
	output ptt_pkg::stat_t   stat
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_CREATE = 6'b000010,
		S_FIND   = 6'b000100,
		S_SHIFT  = 6'b001000,
		S_TICK   = 6'b010000,
		S_RESP   = 6'b100000
	} state_t;

	state_t                          state_q, state_d;
	logic [ptt_pkg::CNT_W-1:0]       count_q, count_d;
	logic [ptt_pkg::CNT_W-1:0]       ptr_q, ptr_d;
	logic                            chk_vld_q, chk_vld_d;
	logic [ptt_pkg::IDX_W-1:0]       chk_idx_q, chk_idx_d;
	logic                            pend_vld_q, pend_vld_d;
	logic [7:0]                      pend_id_q, pend_id_d;
	logic [ptt_pkg::RES_W-1:0]       nres_q, nres_d;
	ptt_pkg::res_t                   res_q, res_d;

	logic [7:0]                      id_q;
	logic [31:0]                     period_q;
	logic [31:0]                     now_q;

	ptt_pkg::entry_t                 mem_q [ptt_pkg::TIMER_SLOTS];
	ptt_pkg::entry_t                 rd_data_q;
	logic                            rd_en;
	logic [ptt_pkg::IDX_W-1:0]       rd_addr;
	logic                            we;
	logic [ptt_pkg::IDX_W-1:0]       wr_addr;
	ptt_pkg::entry_t                 wr_data;

	logic                            fire;
	logic                            more_rd;
	logic                            accept;
	logic                            tick_hold;

	ptt_due u_due (
		.entry    (rd_data_q),
		.now_time (now_q),
		.fire     (fire)
	);

	assign accept = in_valid && (state_q == S_IDLE);
	assign more_rd = ptr_q < count_q;
	assign tick_hold = chk_vld_q && fire && pend_vld_q && !out_free;
	assign stat.busy = state_q != S_IDLE;
	assign stat.count = count_q;

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		ptr_d = ptr_q;
		chk_vld_d = chk_vld_q;
		chk_idx_d = chk_idx_q;
		pend_vld_d = pend_vld_q;
		pend_id_d = pend_id_q;
		nres_d = nres_q;
		res_d = res_q;
		rd_en = 1'b0;
		rd_addr = ptr_q[ptt_pkg::IDX_W-1:0];
		we = 1'b0;
		wr_addr = chk_idx_q;
		wr_data = rd_data_q;
		push = 1'b0;
		res = res_q;
		case (state_q)
			S_IDLE: begin
				ptr_d = '0;
				chk_vld_d = 1'b0;
				pend_vld_d = 1'b0;
				nres_d = '0;
				if (in_valid) begin
					case (kind)
						ptt_pkg::KIND_CREATE: state_d = S_CREATE;
						ptt_pkg::KIND_DROP:   state_d = S_FIND;
						ptt_pkg::KIND_TICK:   state_d = S_TICK;
						default:              state_d = S_IDLE;
					endcase
				end
			end
			S_CREATE: begin
				if (out_free) begin
					push = 1'b1;
					if (count_q < ptt_pkg::CNT_W'(ptt_pkg::TIMER_SLOTS)) begin
						res = ptt_pkg::res_t'{id_q, ptt_pkg::ST_CREATED, 1'b1};
						we = 1'b1;
						wr_addr = count_q[ptt_pkg::IDX_W-1:0];
						wr_data = ptt_pkg::entry_t'{id_q, period_q, now_q};
						count_d = count_q + 1'b1;
					end else begin
						res = ptt_pkg::res_t'{id_q, ptt_pkg::ST_FULL, 1'b1};
					end
					state_d = S_IDLE;
				end
			end
			S_FIND: begin
				if (more_rd) begin
					rd_en = 1'b1;
					ptr_d = ptr_q + 1'b1;
					chk_vld_d = 1'b1;
					chk_idx_d = ptr_q[ptt_pkg::IDX_W-1:0];
				end else begin
					chk_vld_d = 1'b0;
				end
				if (chk_vld_q && (rd_data_q.id == id_q)) begin
					state_d = S_SHIFT;
					ptr_d = {1'b0, chk_idx_q} + 1'b1;
					chk_vld_d = 1'b0;
				end else if (!chk_vld_q && !more_rd) begin
					res_d = ptt_pkg::res_t'{id_q, ptt_pkg::ST_NOT_FOUND, 1'b1};
					state_d = S_RESP;
				end
			end
			S_SHIFT: begin
				if (more_rd) begin
					rd_en = 1'b1;
					ptr_d = ptr_q + 1'b1;
					chk_vld_d = 1'b1;
					chk_idx_d = ptr_q[ptt_pkg::IDX_W-1:0];
				end else begin
					chk_vld_d = 1'b0;
				end
				if (chk_vld_q) begin
					we = 1'b1;
					wr_addr = chk_idx_q - 1'b1;
				end else if (!more_rd) begin
					count_d = count_q - 1'b1;
					res_d = ptt_pkg::res_t'{id_q, ptt_pkg::ST_DROPPED, 1'b1};
					state_d = S_RESP;
				end
			end
			S_TICK: begin
				if (!tick_hold) begin
					if (more_rd) begin
						rd_en = 1'b1;
						ptr_d = ptr_q + 1'b1;
						chk_vld_d = 1'b1;
						chk_idx_d = ptr_q[ptt_pkg::IDX_W-1:0];
					end else begin
						chk_vld_d = 1'b0;
					end
					if (chk_vld_q && fire) begin
						we = 1'b1;
						wr_data = ptt_pkg::entry_t'{rd_data_q.id, rd_data_q.period, now_q};
						if (pend_vld_q) begin
							push = 1'b1;
							res = ptt_pkg::res_t'{pend_id_q, ptt_pkg::ST_FIRED, 1'b0};
						end
						pend_vld_d = 1'b1;
						pend_id_d = rd_data_q.id;
						nres_d = nres_q + 1'b1;
						if (nres_q == ptt_pkg::RES_W'(ptt_pkg::MAX_RESULTS - 1)) begin
							res_d = ptt_pkg::res_t'{rd_data_q.id, ptt_pkg::ST_FIRED, 1'b1};
							state_d = S_RESP;
						end
					end else if (!chk_vld_q && !more_rd) begin
						if (pend_vld_q) begin
							res_d = ptt_pkg::res_t'{pend_id_q, ptt_pkg::ST_FIRED, 1'b1};
						end else begin
							res_d = ptt_pkg::res_t'{8'd0, ptt_pkg::ST_NO_FIRE, 1'b1};
						end
						state_d = S_RESP;
					end
				end
			end
			S_RESP: begin
				if (out_free) begin
					push = 1'b1;
					res = res_q;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ptr_q <= '0;
			chk_vld_q <= 1'b0;
			pend_vld_q <= 1'b0;
			nres_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			ptr_q <= ptr_d;
			chk_vld_q <= chk_vld_d;
			pend_vld_q <= pend_vld_d;
			nres_q <= nres_d;
		end
	end

	always_ff @(posedge clk) begin
		chk_idx_q <= chk_idx_d;
		pend_id_q <= pend_id_d;
		res_q <= res_d;
		if (accept) begin
			id_q <= timer_id;
			period_q <= period;
			now_q <= now_time;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

endmodule
